>>> rtl/seek_pursue_return_drive_controller_macros.svh
// assertion macros shared by the drive controller rtl
// depends on a clk and an active-low rst_n in the scope of each use
`ifndef SEEK_PURSUE_RETURN_DRIVE_CONTROLLER_MACROS_SVH
`define SEEK_PURSUE_RETURN_DRIVE_CONTROLLER_MACROS_SVH

`ifndef SYNTHESIS
// checked only out of reset
`define SPRDC_ASSERT(name, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("%m: check failed");
// checked at every edge, reset included
`define SPRDC_ASSERT_ALWAYS(name, prop) \
    name: assert property (@(posedge clk) (prop)) \
        else $error("%m: check failed");
`else
`define SPRDC_ASSERT(name, prop)
`define SPRDC_ASSERT_ALWAYS(name, prop)
`endif

`endif

>>> rtl/sprdc_pkg.sv
// types, constants and helpers for the seek / pursue / return drive controller
// used by sprdc_decide and seek_pursue_return_drive_controller
`timescale 1ns / 1ps

package sprdc_pkg;

    localparam int CONFIRM_TICKS = 500;
    localparam int CNT_W         = 10;
    localparam int LINE_WIDTH    = 640;
    localparam int LINE_CENTER   = LINE_WIDTH / 2;
    localparam int STEER_GAIN    = 2;

    // configuration register indexes
    localparam logic [2:0] REG_MAX_RANGE  = 3'd0;
    localparam logic [2:0] REG_CRUISE     = 3'd1;
    localparam logic [2:0] REG_GOAL       = 3'd2;
    localparam logic [2:0] REG_ERR_THR    = 3'd3;
    localparam logic [2:0] REG_MAX_SUM    = 3'd4;
    localparam logic [2:0] REG_KP         = 3'd5;
    localparam logic [2:0] REG_KI         = 3'd6;
    localparam logic [2:0] REG_STEER_DB   = 3'd7;

    typedef enum logic [1:0] {
        PH_TURN     = 2'd0,
        PH_PURSUIT  = 2'd1,
        PH_COMEBACK = 2'd2
    } phase_t;

    typedef enum logic [2:0] {
        ACT_KEEP = 3'd0,
        ACT_STOP = 3'd1,
        ACT_SPIN = 3'd2,
        ACT_FAST = 3'd3,
        ACT_PI   = 3'd4
    } act_t;

    typedef struct packed {
        logic [12:0] max_range_mm;
        logic [13:0] cruise_speed;
        logic [15:0] goal_dist;
        logic [15:0] err_deadband;
        logic [23:0] sum_limit;
        logic [23:0] kp;
        logic [23:0] ki;
        logic [9:0]  steer_deadband;
    } cfg_t;

    typedef struct packed {
        logic        home_reached;
        logic        heading_reached;
        logic        near_reached;
        logic [9:0]  line_position;
        logic [15:0] camera_distance;
        logic [12:0] confirm_range_mm;
        logic [12:0] range_mm;
    } item_t;

    // decision for one item, out of the control stage
    typedef struct packed {
        act_t               act;
        phase_t             phase;
        logic               clear;
        logic               pi_on;
        logic [15:0]        err;
        logic [23:0]        integral;
        logic signed [15:0] steer;
    } dec_t;

    // products stage
    typedef struct packed {
        act_t               act;
        phase_t             phase;
        logic               clear;
        logic signed [15:0] steer;
        logic [39:0]        prod_p;
        logic [47:0]        prod_i;
    } prod_t;

    function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
        logic signed [15:0] r;
        if (v > 18'sd32767)
            r = 16'sh7FFF;
        else if (v < -18'sd32768)
            r = 16'sh8000;
        else
            r = v[15:0];
        return r;
    endfunction

endpackage

>>> rtl/sprdc_decide.sv
// control stage: phase machine, detection counter and error integral
// depends on sprdc_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "seek_pursue_return_drive_controller_macros.svh"

module sprdc_decide (
    input  logic             clk,
    input  logic             rst_n,
    input  sprdc_pkg::cfg_t  cfg,
    input  sprdc_pkg::item_t item,
    input  logic             fire,
    output sprdc_pkg::dec_t  dec
);
    import sprdc_pkg::*;

    phase_t             mode_reg, mode_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [23:0]        integral_reg, integral_next;

    logic [16:0]        err_full;
    logic               pi_on_w;
    logic [24:0]        int_sum;
    logic [23:0]        int_clamped;
    logic signed [10:0] offset;
    logic signed [10:0] offset_mag;
    logic signed [10:0] offset_eff;
    logic signed [15:0] steer_w;

    // error, clamped integral and steering term
    always_comb
    begin
        err_full    = {1'b0, item.camera_distance} - {1'b0, cfg.goal_dist};
        pi_on_w     = !err_full[16] && (err_full[15:0] >= cfg.err_deadband);
        int_sum     = {1'b0, integral_reg} + {9'b0, err_full[15:0]};
        int_clamped = (int_sum > {1'b0, cfg.sum_limit}) ? cfg.sum_limit
                                                        : int_sum[23:0];
        offset      = $signed({1'b0, item.line_position}) - $signed(11'(LINE_CENTER));
        offset_mag  = offset[10] ? -offset : offset;
        offset_eff  = (offset_mag < $signed({1'b0, cfg.steer_deadband})) ? 11'sd0 : offset;
        steer_w     = 16'(offset_eff) * $signed(16'(STEER_GAIN));
    end

    always_comb
    begin
        mode_next     = mode_reg;
        count_next    = count_reg;
        integral_next = integral_reg;
        dec.act       = ACT_KEEP;
        dec.clear     = 1'b0;
        dec.pi_on     = 1'b0;
        case (mode_reg)
            PH_TURN:
            begin
                if (item.range_mm < cfg.max_range_mm)
                begin
                    if (count_reg >= CNT_W'(CONFIRM_TICKS))
                    begin
                        if (item.confirm_range_mm <= cfg.max_range_mm)
                        begin
                            dec.act   = ACT_STOP;
                            mode_next = PH_PURSUIT;
                        end
                        else
                        begin
                            dec.act = ACT_SPIN;
                        end
                    end
                    else
                    begin
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                else
                begin
                    dec.act = ACT_SPIN;
                end
            end
            PH_PURSUIT:
            begin
                if (item.near_reached)
                begin
                    dec.act   = ACT_STOP;
                    mode_next = PH_COMEBACK;
                end
                else
                begin
                    dec.act = ACT_PI;
                    if (pi_on_w)
                    begin
                        dec.pi_on     = 1'b1;
                        integral_next = int_clamped;
                    end
                end
            end
            PH_COMEBACK:
            begin
                if (item.heading_reached)
                begin
                    if (item.home_reached)
                    begin
                        dec.act   = ACT_STOP;
                        dec.clear = 1'b1;
                        mode_next = PH_TURN;
                    end
                    else
                    begin
                        dec.act = ACT_FAST;
                    end
                end
                else
                begin
                    dec.act = ACT_SPIN;
                end
            end
            default:
            begin
                dec.act   = ACT_STOP;
                mode_next = PH_TURN;
            end
        endcase
        dec.phase    = mode_next;
        dec.err      = err_full[15:0];
        dec.integral = integral_next;
        dec.steer    = steer_w;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= PH_TURN;
            count_reg    <= '0;
            integral_reg <= '0;
        end
        else if (fire)
        begin
            mode_reg     <= mode_next;
            count_reg    <= count_next;
            integral_reg <= integral_next;
        end
    end

    `SPRDC_ASSERT_ALWAYS(a_count_bounded, count_reg <= CNT_W'(CONFIRM_TICKS))
    `SPRDC_ASSERT(a_pursuit_after_count,
        (fire && mode_reg == PH_TURN && mode_next == PH_PURSUIT)
            |-> (count_reg == CNT_W'(CONFIRM_TICKS)))
    `SPRDC_ASSERT(a_integral_clamped,
        (fire && dec.pi_on) |=> (integral_reg <= cfg.sum_limit))

endmodule

>>> rtl/seek_pursue_return_drive_controller.sv
// seek / pursue / return drive controller, top level
// depends on sprdc_pkg, sprdc_decide and the assertion macro header
`timescale 1ns / 1ps
`include "seek_pursue_return_drive_controller_macros.svh"

// usage
//   s_* carries one control tick per item, m_* returns one wheel command
//   item per tick, in order. the apb port sets the eight tuning registers
//   and the user writes it only while no item is in flight; the block
//   does not enforce this. an item goes through an input register, the
//   control stage (phase, detection counter and integral update), the
//   multiply stage (kp and ki products) and the output register, whose
//   valid drives m_tvalid. one item per cycle is taken in steady state
//   while m_tready is high; the two 24-bit multipliers set the stage depth.
//   reset puts the block in the turn phase with counter, integral and
//   wheel commands at zero and the registers at their default values.
//   when m_tready is low the output register holds its item and the
//   stages behind it keep filling, so up to four items are held before
//   s_tready drops.
module seek_pursue_return_drive_controller (
    input  logic        clk,
    input  logic        rst_n,
    // apb configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input items
    input  logic        s_tvalid,
    output logic        s_tready,
    // range_mm[12:0], confirm_range_mm[25:13], camera_distance[41:26],
    // line_position[51:42], near_reached[52], heading_reached[53],
    // home_reached[54], zero[55]
    input  logic [55:0] s_tdata,
    // result items
    output logic        m_tvalid,
    input  logic        m_tready,
    // right_wheel[15:0], left_wheel[31:16], phase[33:32], clear_pulse[34],
    // zero[39:35]
    output logic [39:0] m_tdata
);
    import sprdc_pkg::*;

    cfg_t               cfg_reg;
    logic               cfg_wr;

    logic               s0_valid_reg, s1_valid_reg, s2_valid_reg, out_valid_reg;
    item_t              s0_reg;
    dec_t               dec_w;
    dec_t               s1_reg;
    prod_t              s2_reg, s2_next;

    logic               ld0, ld1, ld2, ld3;
    logic               s1_open, s2_open;

    logic signed [15:0] right_cmd_reg, left_cmd_reg, right_next, left_next;
    phase_t             phase_reg;
    logic               clear_reg;

    logic [48:0]        acc;
    logic [15:0]        speed;
    logic signed [17:0] right_raw, left_raw;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_range_mm   <= 13'd150;
            cfg_reg.cruise_speed   <= 14'd200;
            cfg_reg.goal_dist      <= 16'd2560;
            cfg_reg.err_deadband   <= 16'd26;
            cfg_reg.sum_limit      <= 24'd25600;
            cfg_reg.kp             <= 24'd204800;
            cfg_reg.ki             <= 24'd896;
            cfg_reg.steer_deadband <= 10'd10;
        end
        else if (cfg_wr)
        begin
            case (paddr[4:2])
                REG_MAX_RANGE: cfg_reg.max_range_mm   <= pwdata[12:0];
                REG_CRUISE:    cfg_reg.cruise_speed   <= pwdata[13:0];
                REG_GOAL:      cfg_reg.goal_dist      <= pwdata[15:0];
                REG_ERR_THR:   cfg_reg.err_deadband   <= pwdata[15:0];
                REG_MAX_SUM:   cfg_reg.sum_limit      <= pwdata[23:0];
                REG_KP:        cfg_reg.kp             <= pwdata[23:0];
                REG_KI:        cfg_reg.ki             <= pwdata[23:0];
                REG_STEER_DB:  cfg_reg.steer_deadband <= pwdata[9:0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[4:2])
            REG_MAX_RANGE: prdata = {19'b0, cfg_reg.max_range_mm};
            REG_CRUISE:    prdata = {18'b0, cfg_reg.cruise_speed};
            REG_GOAL:      prdata = {16'b0, cfg_reg.goal_dist};
            REG_ERR_THR:   prdata = {16'b0, cfg_reg.err_deadband};
            REG_MAX_SUM:   prdata = {8'b0, cfg_reg.sum_limit};
            REG_KP:        prdata = {8'b0, cfg_reg.kp};
            REG_KI:        prdata = {8'b0, cfg_reg.ki};
            REG_STEER_DB:  prdata = {22'b0, cfg_reg.steer_deadband};
            default:       prdata = '0;
        endcase
    end

    // stage handshakes, each stage moves when the one ahead has room
    assign ld3      = s2_valid_reg && (!out_valid_reg || m_tready);
    assign s2_open  = !s2_valid_reg || ld3;
    assign ld2      = s1_valid_reg && s2_open;
    assign s1_open  = !s1_valid_reg || ld2;
    assign ld1      = s0_valid_reg && s1_open;
    assign s_tready = !s0_valid_reg || ld1;
    assign ld0      = s_tvalid && s_tready;

    sprdc_decide u_decide (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_reg),
        .item  (s0_reg),
        .fire  (ld1),
        .dec   (dec_w)
    );

    // products of the pi regulator
    always_comb
    begin
        s2_next.act    = s1_reg.act;
        s2_next.phase  = s1_reg.phase;
        s2_next.clear  = s1_reg.clear;
        s2_next.steer  = s1_reg.steer;
        s2_next.prod_p = s1_reg.pi_on ? (cfg_reg.kp * s1_reg.err) : 40'd0;
        s2_next.prod_i = s1_reg.pi_on ? (cfg_reg.ki * s1_reg.integral) : 48'd0;
    end

    // speed, steering split and wheel selection
    always_comb
    begin
        acc        = {9'b0, s2_reg.prod_p} + {1'b0, s2_reg.prod_i};
        speed      = (|acc[48:31]) ? 16'h7FFF : {1'b0, acc[30:16]};
        right_raw  = $signed({2'b0, speed}) - 18'(s2_reg.steer);
        left_raw   = $signed({2'b0, speed}) + 18'(s2_reg.steer);
        right_next = right_cmd_reg;
        left_next  = left_cmd_reg;
        case (s2_reg.act)
            ACT_KEEP:
            begin
                right_next = right_cmd_reg;
                left_next  = left_cmd_reg;
            end
            ACT_STOP:
            begin
                right_next = '0;
                left_next  = '0;
            end
            ACT_SPIN:
            begin
                right_next = $signed({2'b0, cfg_reg.cruise_speed});
                left_next  = -$signed({2'b0, cfg_reg.cruise_speed});
            end
            ACT_FAST:
            begin
                right_next = $signed({1'b0, cfg_reg.cruise_speed, 1'b0});
                left_next  = $signed({1'b0, cfg_reg.cruise_speed, 1'b0});
            end
            ACT_PI:
            begin
                right_next = sat16(right_raw);
                left_next  = sat16(left_raw);
            end
            default:
            begin
                right_next = right_cmd_reg;
                left_next  = left_cmd_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg  <= 1'b0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            right_cmd_reg <= '0;
            left_cmd_reg  <= '0;
            phase_reg     <= PH_TURN;
            clear_reg     <= 1'b0;
        end
        else
        begin
            s0_valid_reg  <= ld0 || (s0_valid_reg && !ld1);
            s1_valid_reg  <= ld1 || (s1_valid_reg && !ld2);
            s2_valid_reg  <= ld2 || (s2_valid_reg && !ld3);
            out_valid_reg <= ld3 || (out_valid_reg && !m_tready);
            // the wheel command registers double as the held speeds
            if (ld3)
            begin
                right_cmd_reg <= right_next;
                left_cmd_reg  <= left_next;
                phase_reg     <= s2_reg.phase;
                clear_reg     <= s2_reg.clear;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld0)
            s0_reg <= item_t'(s_tdata[54:0]);
        if (ld1)
            s1_reg <= dec_w;
        if (ld2)
            s2_reg <= s2_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b0, clear_reg, phase_reg, left_cmd_reg, right_cmd_reg};

    `SPRDC_ASSERT(a_clear_stops_in_turn,
        (out_valid_reg && clear_reg)
            |-> (right_cmd_reg == 16'sd0 && left_cmd_reg == 16'sd0 && phase_reg == PH_TURN))
    `SPRDC_ASSERT(a_comeback_wheels,
        (out_valid_reg && phase_reg == PH_COMEBACK)
            |-> (right_cmd_reg == left_cmd_reg || (right_cmd_reg + left_cmd_reg) == 16'sd0))
    `SPRDC_ASSERT(a_stage_holds_on_stall,
        (s2_valid_reg && !ld3) |=> (s2_valid_reg && $stable(s2_reg)))

endmodule
